FILE: rtl/idm_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the IDM acceleration block.
// No dependencies; idm_if and idm_car_following_accel import this package, idm_div does not.
`default_nettype none

package idm_pkg;

	localparam int SPEED_W   = 16;
	localparam int DELTA_W   = 17;
	localparam int GAP_W     = 24;
	localparam int ACC_W     = 13;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int POW_STEPS = 15;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_HEADWAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_EXP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 3'd4;

	localparam logic [11:0] RST_TIME_HEADWAY = 12'd384;
	localparam logic [11:0] RST_MAX_ACCEL    = 12'd256;
	localparam logic [11:0] RST_MAX_DECEL    = 12'd768;
	localparam logic [3:0]  RST_ACCEL_EXP    = 4'd4;
	localparam logic [15:0] RST_MIN_GAP      = 16'd512;

	localparam logic [30:0] ONE_Q16 = 31'd65536;
	localparam logic [30:0] SAT_Q16 = 31'h4000_0000;

	function automatic logic [30:0] sat_q16(input logic [63:0] x);
		logic [30:0] r;
		if (x > {33'd0, SAT_Q16}) begin
			r = SAT_Q16;
		end else begin
			r = x[30:0];
		end
		return r;
	endfunction

	function automatic logic [30:0] round_q16(input logic [61:0] prod);
		logic [62:0] t;
		t = {1'b0, prod} + 63'd32768;
		return sat_q16({17'd0, t[62:16]});
	endfunction

endpackage

`default_nettype wire

FILE: rtl/idm_if.sv
// Channel interfaces of the IDM acceleration block: one per input and result stream.
// Depends on idm_pkg for the field widths.
`default_nettype none

interface idm_in_if;
	import idm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [SPEED_W-1:0]        speed;
	logic [SPEED_W-1:0]        desired_speed;
	logic signed [DELTA_W-1:0] speed_delta;
	logic [GAP_W-1:0]          gap;
	logic                      has_leader;

	modport source(output valid, speed, desired_speed, speed_delta, gap, has_leader,
		input ready);
	modport sink(input valid, speed, desired_speed, speed_delta, gap, has_leader,
		output ready);
endinterface

interface idm_out_if;
	import idm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] acceleration;
	logic                    clamped;

	modport source(output valid, acceleration, clamped, input ready);
	modport sink(input valid, acceleration, clamped, output ready);
endinterface

`default_nettype wire

FILE: rtl/idm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a payload carried alongside.
// Self-contained; instantiated by idm_car_following_accel.
`default_nettype none

module idm_div #(
	parameter int NW = 33,
	parameter int DW = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay,
	output logic          quo_vld,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] quo_pay
);

	logic          vld_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] num_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [PW-1:0] pay_s [NW+1];

	assign vld_s[0] = vld;
	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign pay_s[0] = pay;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (ge) begin
					rem_s[k+1] <= DW'(trial - {1'b0, den_s[k]});
				end else begin
					rem_s[k+1] <= trial[DW-1:0];
				end
				num_s[k+1] <= num_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][NW-2:0], ge};
				den_s[k+1] <= den_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign quo_vld = vld_s[NW];
	assign quo     = quo_s[NW];
	assign quo_pay = pay_s[NW];

endmodule

`default_nettype wire

FILE: rtl/idm_car_following_accel.sv
// One item is accepted every cycle unless the skid register is full or sqrt(a*b) is recomputed.
// The three long divisions (free ratio, brake gap, busy ratio) set the depth, one bit a stage.
// A one-entry skid register at the output takes a result that the receiver refuses; while it
// is full the whole pipeline holds, and no input transfer is accepted.
// Reset is asynchronous, active low; after reset and after every write of max_accel or
// max_decel, sqrt(a*b) is recomputed, and no input is accepted until that is done.
// Depends on idm_pkg, idm_if and idm_div.
`default_nettype none

module idm_car_following_accel
	import idm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	idm_in_if.sink               sample,
	idm_out_if.source            result
);

	typedef struct packed {
		logic [15:0]        v;
		logic signed [16:0] dv;
		logic [23:0]        s;
		logic               lead;
		logic               v0z;
	} item_t;

	typedef struct packed {
		item_t       it;
		logic [30:0] r;
		logic [30:0] p;
	} pw_t;

	typedef struct packed {
		logic [30:0] free;
		logic [27:0] vt;
		logic [23:0] s;
		logic        lead;
		logic        dvneg;
	} bz_t;

	typedef struct packed {
		logic [30:0] free;
		logic [23:0] s;
		logic        lead;
	} cx_t;

	typedef struct packed {
		logic [30:0] free;
		logic        lead;
		logic        szero;
	} rx_t;

	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_MUL  = 2'd1;
	localparam logic [1:0] SQ_RUN  = 2'd2;

	// Configuration registers.
	logic [11:0] time_headway_q, max_accel_q, max_decel_q;
	logic [3:0]  accel_exp_q;
	logic [15:0] min_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_headway_q <= RST_TIME_HEADWAY;
			max_accel_q    <= RST_MAX_ACCEL;
			max_decel_q    <= RST_MAX_DECEL;
			accel_exp_q    <= RST_ACCEL_EXP;
			min_gap_q      <= RST_MIN_GAP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIME_HEADWAY: time_headway_q <= cfg_data[11:0];
				REG_MAX_ACCEL:    max_accel_q    <= cfg_data[11:0];
				REG_MAX_DECEL:    max_decel_q    <= cfg_data[11:0];
				REG_ACCEL_EXP:    accel_exp_q    <= cfg_data[3:0];
				REG_MIN_GAP:      min_gap_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Square root of a*b, recomputed after reset and on every write of a or b.
	logic [1:0]  sq_state_q;
	logic [3:0]  sq_cnt_q;
	logic [23:0] sq_x_q, sq_r_q;
	logic [11:0] q_q;
	logic [4:0]  sq_sh;
	logic [23:0] sq_bit, sq_x_nxt, sq_r_nxt;
	logic [24:0] sq_try;
	logic        cfg_ab_wr;

	assign cfg_ab_wr = cfg_wr_en &&
		(cfg_index == REG_MAX_ACCEL || cfg_index == REG_MAX_DECEL);
	assign sq_sh  = 5'd22 - {sq_cnt_q, 1'b0};
	assign sq_bit = 24'd1 << sq_sh;
	assign sq_try = {1'b0, sq_r_q} + {1'b0, sq_bit};

	always_comb begin
		if ({1'b0, sq_x_q} >= sq_try) begin
			sq_x_nxt = sq_x_q - sq_try[23:0];
			sq_r_nxt = (sq_r_q >> 1) + sq_bit;
		end else begin
			sq_x_nxt = sq_x_q;
			sq_r_nxt = sq_r_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_state_q <= SQ_MUL;
			sq_cnt_q   <= '0;
			sq_x_q     <= '0;
			sq_r_q     <= '0;
			q_q        <= 12'd1;
		end else if (cfg_ab_wr) begin
			sq_state_q <= SQ_MUL;
		end else begin
			unique case (sq_state_q)
				SQ_IDLE: ;
				SQ_MUL: begin
					sq_x_q     <= {12'd0, max_accel_q} * {12'd0, max_decel_q};
					sq_r_q     <= '0;
					sq_cnt_q   <= '0;
					sq_state_q <= SQ_RUN;
				end
				SQ_RUN: begin
					sq_x_q   <= sq_x_nxt;
					sq_r_q   <= sq_r_nxt;
					sq_cnt_q <= sq_cnt_q + 4'd1;
					if (sq_cnt_q == 4'd11) begin
						sq_state_q <= SQ_IDLE;
						q_q <= (sq_r_nxt[11:0] == 12'd0) ? 12'd1 : sq_r_nxt[11:0];
					end
				end
				default: sq_state_q <= SQ_MUL;
			endcase
		end
	end

	// Flow control: the whole pipeline advances unless the skid register is occupied.
	logic skid_v_q;
	logic en, take;

	assign en           = !skid_v_q;
	assign sample.ready = en && (sq_state_q == SQ_IDLE);
	assign take         = sample.valid && sample.ready;

	// Stage 1: input register.
	logic        vld_s1;
	item_t       it_s1;
	logic [15:0] v0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.v    <= sample.speed;
			it_s1.dv   <= sample.speed_delta;
			it_s1.s    <= sample.gap;
			it_s1.lead <= sample.has_leader;
			it_s1.v0z  <= sample.desired_speed == 16'd0;
			v0_s1      <= sample.desired_speed;
		end
	end

	// Free-road ratio v/v0.
	logic [32:0]              fdiv_num;
	logic [15:0]              fdiv_den;
	logic                     fdiv_vld;
	logic [32:0]              fdiv_quo;
	logic [$bits(item_t)-1:0] fdiv_pay;

	assign fdiv_num = {1'b0, it_s1.v, 16'd0} + {18'd0, v0_s1[15:1]};
	assign fdiv_den = (v0_s1 == 16'd0) ? 16'd1 : v0_s1;

	idm_div #(.NW(33), .DW(16), .PW($bits(item_t))) u_div_free (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(vld_s1), .num(fdiv_num), .den(fdiv_den), .pay(it_s1),
		.quo_vld(fdiv_vld), .quo(fdiv_quo), .quo_pay(fdiv_pay)
	);

	// Power (v/v0)^delta: each step is a multiply stage then a round-and-saturate stage.
	pw_t         pw_a_s [POW_STEPS+1];
	pw_t         pw_m_s [POW_STEPS];
	logic [61:0] pr_s   [POW_STEPS];
	logic        va_s   [POW_STEPS+1];
	logic        vm_s   [POW_STEPS];

	assign va_s[0]      = fdiv_vld;
	assign pw_a_s[0].it = item_t'(fdiv_pay);
	assign pw_a_s[0].r  = sat_q16({31'd0, fdiv_quo});
	assign pw_a_s[0].p  = ONE_Q16;

	for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vm_s[k]   <= 1'b0;
				va_s[k+1] <= 1'b0;
			end else if (en) begin
				vm_s[k]   <= va_s[k];
				va_s[k+1] <= vm_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pw_m_s[k]      <= pw_a_s[k];
				pr_s[k]        <= {31'd0, pw_a_s[k].p} * {31'd0, pw_a_s[k].r};
				pw_a_s[k+1].it <= pw_m_s[k].it;
				pw_a_s[k+1].r  <= pw_m_s[k].r;
				if (4'(k) < accel_exp_q) begin
					pw_a_s[k+1].p <= round_q16(pr_s[k]);
				end else begin
					pw_a_s[k+1].p <= pw_m_s[k].p;
				end
			end
		end
	end

	// Stage 3: v*|dv| and v*T.
	pw_t         pw_end;
	logic [16:0] dv_abs;
	logic        vld_s3;
	logic [31:0] mag_s3;
	bz_t         bz_s3;
	logic [32:0] mag_full;

	assign pw_end   = pw_a_s[POW_STEPS];
	assign dv_abs   = pw_end.it.dv[16] ? 17'(17'd0 - pw_end.it.dv) : pw_end.it.dv;
	assign mag_full = {17'd0, pw_end.it.v} * {16'd0, dv_abs};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3      <= mag_full[31:0];
			bz_s3.free  <= pw_end.it.v0z ? ONE_Q16 : pw_end.p;
			bz_s3.vt    <= {12'd0, pw_end.it.v} * {16'd0, time_headway_q};
			bz_s3.s     <= pw_end.it.s;
			bz_s3.lead  <= pw_end.it.lead;
			bz_s3.dvneg <= pw_end.it.dv[16];
		end
	end

	// Brake gap v*|dv| / (2*sqrt(ab)).
	logic [40:0]            bdiv_num;
	logic [12:0]            bdiv_den;
	logic                   bdiv_vld;
	logic [40:0]            bdiv_quo;
	logic [$bits(bz_t)-1:0] bdiv_pay;
	bz_t                    bz_o;

	assign bdiv_num = {1'b0, mag_s3, 8'd0} + {29'd0, q_q};
	assign bdiv_den = {q_q, 1'b0};
	assign bz_o     = bz_t'(bdiv_pay);

	idm_div #(.NW(41), .DW(13), .PW($bits(bz_t))) u_div_brake (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(vld_s3), .num(bdiv_num), .den(bdiv_den), .pay(bz_s3),
		.quo_vld(bdiv_vld), .quo(bdiv_quo), .quo_pay(bdiv_pay)
	);

	// Stage 4: desired gap; stage 5: its magnitude.
	logic signed [41:0] base, brk;
	logic signed [41:0] sstar_s4;
	logic [40:0]        abs_s5;
	cx_t                cx_s4, cx_s5;
	logic               vld_s4, vld_s5;

	assign base = $signed({18'd0, min_gap_q, 8'd0}) + $signed({14'd0, bz_o.vt});
	assign brk  = $signed({1'b0, bdiv_quo});

	always_ff @(posedge clk) begin
		if (en) begin
			sstar_s4   <= bz_o.dvneg ? base - brk : base + brk;
			cx_s4.free <= bz_o.free;
			cx_s4.s    <= bz_o.s;
			cx_s4.lead <= bz_o.lead;
			abs_s5     <= sstar_s4[41] ? 41'(42'd0 - sstar_s4) : sstar_s4[40:0];
			cx_s5      <= cx_s4;
		end
	end

	// Busy ratio |s*|/s.
	logic [49:0]            rdiv_num;
	logic [23:0]            rdiv_den;
	rx_t                    rx_in;
	logic                   rdiv_vld;
	logic [49:0]            rdiv_quo;
	logic [$bits(rx_t)-1:0] rdiv_pay;

	assign rdiv_num    = {1'b0, abs_s5, 8'd0} + {27'd0, cx_s5.s[23:1]};
	assign rdiv_den    = (cx_s5.s == 24'd0) ? 24'd1 : cx_s5.s;
	assign rx_in.free  = cx_s5.free;
	assign rx_in.lead  = cx_s5.lead;
	assign rx_in.szero = cx_s5.s == 24'd0;

	idm_div #(.NW(50), .DW(24), .PW($bits(rx_t))) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld(vld_s5), .num(rdiv_num), .den(rdiv_den), .pay(rx_in),
		.quo_vld(rdiv_vld), .quo(rdiv_quo), .quo_pay(rdiv_pay)
	);

	// Stages 6 to 11: square, combine, scale by a, clamp and round.
	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	rx_t                rx_s6, rx_s7, rx_s8;
	logic [30:0]        r2_s6, busy_s8;
	logic [61:0]        sq_s7;
	logic signed [32:0] x_s9;
	logic signed [45:0] p_s10;
	logic signed [45:0] hi, lo, rnd;
	logic [ACC_W-1:0]   acc_s11;
	logic               clamped_s11;

	assign hi  = $signed({18'd0, max_accel_q, 16'd0});
	assign lo  = 46'sd0 - $signed({18'd0, max_decel_q, 16'd0});
	assign rnd = p_s10 + 46'sd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s6   <= sat_q16({14'd0, rdiv_quo});
			rx_s6   <= rx_t'(rdiv_pay);
			sq_s7   <= {31'd0, r2_s6} * {31'd0, r2_s6};
			rx_s7   <= rx_s6;
			busy_s8 <= rx_s7.szero ? SAT_Q16 : round_q16(sq_s7);
			rx_s8   <= rx_s7;
			x_s9    <= $signed({2'b0, ONE_Q16}) - $signed({2'b0, rx_s8.free})
				- (rx_s8.lead ? $signed({2'b0, busy_s8}) : 33'sd0);
			p_s10   <= $signed({1'b0, max_accel_q}) * x_s9;
			if (p_s10 < lo) begin
				acc_s11     <= 13'd0 - {1'b0, max_decel_q};
				clamped_s11 <= 1'b1;
			end else if (p_s10 > hi) begin
				acc_s11     <= {1'b0, max_accel_q};
				clamped_s11 <= 1'b1;
			end else begin
				acc_s11     <= rnd[28:16];
				clamped_s11 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s3  <= va_s[POW_STEPS];
			vld_s4  <= bdiv_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= rdiv_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Output skid register.
	logic [ACC_W-1:0] skid_acc_q;
	logic             skid_clamped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld_s11 && !result.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && vld_s11 && !result.ready) begin
			skid_acc_q     <= acc_s11;
			skid_clamped_q <= clamped_s11;
		end
	end

	assign result.valid        = skid_v_q || vld_s11;
	assign result.acceleration = skid_v_q ? skid_acc_q : acc_s11;
	assign result.clamped      = skid_v_q ? skid_clamped_q : clamped_s11;

	a_sqrt_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_state_q != SQ_IDLE) |-> !sample.ready)
		else $error("input accepted while sqrt(a*b) is being recomputed");

	a_ab_write_recomputes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ab_wr |=> !sample.ready)
		else $error("write of a or b did not start a sqrt recomputation");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.acceleration) <= $signed({1'b0, max_accel_q})
			&& $signed(result.acceleration) >= 13'sd0 - $signed({1'b0, max_decel_q})))
		else $error("acceleration outside [-b, a]");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clamped) |->
			(result.acceleration == {1'b0, max_accel_q}
			|| result.acceleration == 13'd0 - {1'b0, max_decel_q}))
		else $error("clamped result not at a limit");

	a_skid_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> ($stable(vld_s11) && $stable(acc_s11)))
		else $error("pipeline advanced while skid register held a result");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for idm_car_following_accel: directed rows then random car items.
// Expected accelerations come from the directed rows where given, else from a predictor of the block kept in this file.
// Depends on idm_pkg, idm_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import idm_pkg::*;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES = 6;
	localparam int SETTLE_CYCLES = 180;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [15:0]        v;
		logic [15:0]        v0;
		logic signed [16:0] dv;
		logic [23:0]        s;
		logic               lead;
	} car_t;

	typedef struct {
		logic signed [12:0] acc;
		logic               clamped;
	} accel_t;

	typedef struct {
		car_t   car;
		logic   known;
		accel_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	idm_in_if in_ch();
	idm_out_if out_ch();

	idm_car_following_accel dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(in_ch.sink),
		.result(out_ch.source)
	);

	longint unsigned headway_q, accel_q, decel_q, expo_q, min_gap_q;
	accel_t accel_queue[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int clamps = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int quiet = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned sat30(longint unsigned x);
		return x > (64'd1 << 30) ? (64'd1 << 30) : x;
	endfunction

	function automatic longint unsigned mul16(longint unsigned x, longint unsigned y);
		return sat30((x * y + 64'd32768) >> 16);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 30;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic accel_t predict_accel(car_t c);
		longint unsigned v, v0, s, dvm, free, busy, r, q, brake, num;
		longint dv, sstar, x, p, hi, lo;
		accel_t o;
		v = c.v;
		v0 = c.v0;
		s = c.s;
		dv = c.dv;
		dvm = dv < 0 ? longint'(-dv) : longint'(dv);
		free = 64'd65536;
		if (v0 != 0) begin
			r = sat30(((v << 16) + (v0 >> 1)) / v0);
			for (int k = 0; k < expo_q; k++) free = mul16(free, r);
		end
		x = 65536 - longint'(free);
		if (c.lead) begin
			if (s == 0) begin
				busy = 64'd1 << 30;
			end else begin
				q = int_sqrt(accel_q * decel_q);
				if (q == 0) q = 1;
				brake = (((v * dvm) << 8) + q) / (2 * q);
				sstar = longint'(min_gap_q << 8) + longint'(v * headway_q);
				sstar = dv < 0 ? sstar - longint'(brake) : sstar + longint'(brake);
				num = (sstar < 0 ? longint'(-sstar) : longint'(sstar));
				num = num << 8;
				r = sat30((num + (s >> 1)) / s);
				busy = mul16(r, r);
			end
			x = x - longint'(busy);
		end
		p = longint'(accel_q) * x;
		hi = longint'(accel_q << 16);
		lo = -longint'(decel_q << 16);
		o.clamped = 1'b1;
		if (p < lo) begin
			o.acc = 13'(-longint'(decel_q));
		end else if (p > hi) begin
			o.acc = 13'(accel_q);
		end else begin
			o.acc = 13'((p + 32768) >>> 16);
			o.clamped = 1'b0;
		end
		return o;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(val);
		case (idx)
			REG_TIME_HEADWAY: headway_q = val & 12'hFFF;
			REG_MAX_ACCEL: accel_q = val & 12'hFFF;
			REG_MAX_DECEL: decel_q = val & 12'hFFF;
			REG_ACCEL_EXP: expo_q = val & 4'hF;
			REG_MIN_GAP: min_gap_q = val & 16'hFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_regs(longint unsigned t, longint unsigned a, longint unsigned b,
		longint unsigned e, longint unsigned g);
		write_reg(REG_TIME_HEADWAY, t);
		write_reg(REG_MAX_ACCEL, a);
		write_reg(REG_MAX_DECEL, b);
		write_reg(REG_ACCEL_EXP, e);
		write_reg(REG_MIN_GAP, g);
	endtask

	// Drives one item from the falling edge and holds it until the transfer happens.
	task automatic send_car(car_t c, logic known, accel_t want);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.speed = c.v;
		in_ch.desired_speed = c.v0;
		in_ch.speed_delta = c.dv;
		in_ch.gap = c.s;
		in_ch.has_leader = c.lead;
		forever begin
			@(posedge clk);
			if (in_ch.ready) break;
		end
		accel_queue.push_back(known ? want : predict_accel(c));
		sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic car_t random_car();
		car_t c;
		if ($urandom_range(99) < 75) begin
			c.v = 16'($urandom_range(12000));
			c.v0 = $urandom_range(19) == 0 ? 16'd0 : 16'($urandom_range(12000, 2000));
			c.dv = 17'(int'($urandom_range(3000)) - 1500);
			c.s = $urandom_range(29) == 0 ? 24'd0 : 24'($urandom_range(40000, 200));
			c.lead = $urandom_range(9) != 0;
		end else begin
			c.v = 16'($urandom);
			c.v0 = 16'($urandom);
			c.dv = 17'($urandom);
			c.s = 24'($urandom);
			c.lead = 1'($urandom);
		end
		return c;
	endfunction

	always @(negedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		accel_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (accel_queue.size() == 0) begin
				$error("result with nothing expected: acceleration %0d", out_ch.acceleration);
				errors++;
			end else begin
				w = accel_queue.pop_front();
				if (out_ch.acceleration !== w.acc) begin
					$error("acceleration: expected %0d, got %0d", w.acc, out_ch.acceleration);
					errors++;
				end
				if (out_ch.clamped !== w.clamped) begin
					$error("clamped: expected %0d, got %0d", w.clamped, out_ch.clamped);
					errors++;
				end
				clamps += w.clamped;
			end
			checked++;
		end
	end

	// The run is abandoned when no transfer of either kind happens for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("** idm_car_following_accel: FAILED **");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	row_t rows[$];

	initial begin
		accel_t none;
		none.acc = '0;
		none.clamped = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.speed = '0;
		in_ch.desired_speed = '0;
		in_ch.speed_delta = '0;
		in_ch.gap = '0;
		in_ch.has_leader = 1'b0;
		out_ch.ready = 1'b0;
		headway_q = RST_TIME_HEADWAY;
		accel_q = RST_MAX_ACCEL;
		decel_q = RST_MAX_DECEL;
		expo_q = RST_ACCEL_EXP;
		min_gap_q = RST_MIN_GAP;

		rows = '{
			'{'{16'd0, 16'd0, 17'sd0, 24'd0, 1'b0}, 1'b1, '{13'sd0, 1'b0}},
			'{'{16'd0, 16'd100, 17'sd0, 24'd0, 1'b0}, 1'b1, '{13'sd256, 1'b0}},
			'{'{16'd65535, 16'd1, 17'sd0, 24'd0, 1'b0}, 1'b1, '{-13'sd768, 1'b1}},
			'{'{16'd2560, 16'd5120, 17'sd0, 24'd0, 1'b1}, 1'b1, '{-13'sd768, 1'b1}},
			'{'{16'd65535, 16'd65535, 17'sd65535, 24'hFFFFFF, 1'b1}, 1'b0, none},
			'{'{16'd65535, 16'd65535, -17'sd65535, 24'hFFFFFF, 1'b1}, 1'b0, none},
			'{'{16'd65535, 16'd0, -17'sd65536, 24'd1, 1'b1}, 1'b0, none},
			'{'{16'd5120, 16'd7680, 17'sd256, 24'd12800, 1'b1}, 1'b0, none},
			'{'{16'd5120, 16'd7680, -17'sd256, 24'd12800, 1'b1}, 1'b0, none},
			'{'{16'd7680, 16'd7680, -17'sd30000, 24'd5000, 1'b1}, 1'b0, none},
			'{'{16'd100, 16'd65535, 17'sd0, 24'hFFFFFF, 1'b1}, 1'b0, none},
			'{'{16'd1, 16'd1, 17'sd1, 24'd1, 1'b0}, 1'b0, none},
			'{'{16'd300, 16'd200, 17'sd5, 24'd100000, 1'b1}, 1'b0, none},
			'{'{16'd0, 16'd0, -17'sd1, 24'd2, 1'b1}, 1'b0, none}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_car(rows[i].car, rows[i].known, rows[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle = ph < 2 ? 16 : (ph < 4 ? 45 : 0);
			recv_idle = ph < 2 ? 45 : (ph < 4 ? 16 : 0);
			wait (accel_queue.size() == 0);
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (ph)
				0: set_regs(384, 256, 768, 4, 512);
				1: set_regs(4095, 4095, 4095, 8, 65535);
				2: set_regs(0, 1, 1, 1, 0);
				3: set_regs($urandom_range(4095), $urandom_range(4095, 1),
					$urandom_range(4095, 1), $urandom_range(8, 1), $urandom_range(65535));
				4: set_regs(256, 0, 0, 0, 1024);
				default: set_regs(300, 512, 1024, 2, 768);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) send_car(random_car(), 1'b0, none);
		end

		wait (accel_queue.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d car items over %0d register settings; %0d results checked.",
			sent, PHASES + 1, checked);
		$display("%0d of the results were clamped to a limit.", clamps);
		if (errors == 0) begin
			$display("** idm_car_following_accel: PASSED **");
		end else begin
			$display("** idm_car_following_accel: FAILED **");
		end
		$finish;
	end

endmodule
